@@ rtl/v3a_pkg.sv @@
package v3a_pkg;

   // operation codes
   typedef enum logic [3:0] {
      FUNC_ADD   = 4'd0,
      FUNC_SUB   = 4'd1,
      FUNC_SCALE = 4'd2,
      FUNC_NEG   = 4'd3,
      FUNC_CROSS = 4'd4,
      FUNC_LERP  = 4'd5,
      FUNC_DOT   = 4'd6,
      FUNC_MAG   = 4'd7,
      FUNC_NORM  = 4'd8
   } func_type;

   localparam int DATA_W = 32;

   // results and normalize operands carried beside the root and divide stages
   typedef struct packed {
      logic [3:0]              func;
      logic [DATA_W-1:0]       rx;
      logic [DATA_W-1:0]       ry;
      logic [DATA_W-1:0]       rz;
      logic [DATA_W-1:0]       sc;
      logic                    ovf;
      logic [2:0]              sgn;
      logic [2:0][DATA_W-1:0]  mag_abs;
   } side_type;

endpackage

@@ rtl/vec3_arith_unit.sv @@
// Pipeline from the accepting edge to the rsp_valid strobe: arithmetic stages 0 to 3,
// 32 square-root stages, 1 round stage, FRAC_BITS+1 divide stages and the output
// register.
// Throughput: one transaction per cycle; busy stays low and the receiver cannot stall.
// Reset: synchronous, active high; clears every stage valid bit, payload is not reset.
module vec3_arith_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [3:0]         req_func,
   input  logic signed [31:0] req_ax,
   input  logic signed [31:0] req_ay,
   input  logic signed [31:0] req_az,
   input  logic signed [31:0] req_bx,
   input  logic signed [31:0] req_by,
   input  logic signed [31:0] req_bz,
   input  logic signed [31:0] req_scalar_in,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_rx,
   output logic signed [31:0] rsp_ry,
   output logic signed [31:0] rsp_rz,
   output logic signed [31:0] rsp_scalar_out,
   output logic               rsp_overflow
);
   import v3a_pkg::*;

   localparam int PW = 65;
   localparam int SW = 67;
   localparam int SQ = 32;
   localparam int QW = FRAC_BITS + 1;
   localparam int NW = DATA_W + FRAC_BITS + 1;
   localparam logic signed [SW-1:0] HALF = SW'(64'sd1 <<< (FRAC_BITS - 1));
   localparam logic signed [SW-1:0] MAXV = SW'(64'sh7FFFFFFF);
   localparam logic signed [SW-1:0] MINV = SW'(-64'sd2147483648);

   // round half up, then clamp to 32 bits; top bit is the overflow flag
   function automatic logic [32:0] round_sat(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] t;
      t = (v + HALF) >>> FRAC_BITS;
      if (t > MAXV) begin
         round_sat = {1'b1, 32'h7FFFFFFF};
      end else if (t < MINV) begin
         round_sat = {1'b1, 32'h80000000};
      end else begin
         round_sat = {1'b0, t[31:0]};
      end
   endfunction

   function automatic logic [32:0] sat34(input logic signed [33:0] v);
      if (v > 34'sh07FFFFFFF) begin
         sat34 = {1'b1, 32'h7FFFFFFF};
      end else if (v < -34'sh080000000) begin
         sat34 = {1'b1, 32'h80000000};
      end else begin
         sat34 = {1'b0, v[31:0]};
      end
   endfunction

   assign busy = 1'b0;

   // ---------------- stage 0: operand selection ----------------
   logic signed [31:0] a_in [3];
   logic signed [31:0] b_in [3];
   logic signed [32:0] s_ext;
   logic signed [32:0] beta;
   logic signed [31:0] st0_x_in [6];
   logic signed [32:0] st0_y_in [6];
   logic [2:0]         st0_neg_in;

   logic               st0_v_ff;
   logic [3:0]         st0_func_ff;
   logic signed [31:0] st0_x_ff [6];
   logic signed [32:0] st0_y_ff [6];
   logic [2:0]         st0_neg_ff;
   logic signed [31:0] st0_a_ff [3];
   logic signed [31:0] st0_b_ff [3];

   assign a_in[0] = req_ax;
   assign a_in[1] = req_ay;
   assign a_in[2] = req_az;
   assign b_in[0] = req_bx;
   assign b_in[1] = req_by;
   assign b_in[2] = req_bz;
   assign s_ext = 33'(req_scalar_in);
   assign beta  = (33'sd1 <<< FRAC_BITS) - s_ext;

   // pick two multiplier operand pairs per component
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         st0_x_in[i] = '0;
         st0_y_in[i] = '0;
      end
      st0_neg_in = '0;
      case (req_func)
         FUNC_SCALE: begin
            for (int i = 0; i < 3; i++) begin
               st0_x_in[2*i] = a_in[i];
               st0_y_in[2*i] = s_ext;
            end
         end
         FUNC_CROSS: begin
            st0_x_in[0] = req_ay; st0_y_in[0] = 33'(req_bz);
            st0_x_in[1] = req_az; st0_y_in[1] = 33'(req_by);
            st0_x_in[2] = req_az; st0_y_in[2] = 33'(req_bx);
            st0_x_in[3] = req_ax; st0_y_in[3] = 33'(req_bz);
            st0_x_in[4] = req_ax; st0_y_in[4] = 33'(req_by);
            st0_x_in[5] = req_ay; st0_y_in[5] = 33'(req_bx);
            st0_neg_in  = 3'b111;
         end
         FUNC_LERP: begin
            for (int i = 0; i < 3; i++) begin
               st0_x_in[2*i]   = a_in[i];
               st0_y_in[2*i]   = s_ext;
               st0_x_in[2*i+1] = b_in[i];
               st0_y_in[2*i+1] = beta;
            end
         end
         FUNC_DOT: begin
            for (int i = 0; i < 3; i++) begin
               st0_x_in[2*i] = a_in[i];
               st0_y_in[2*i] = 33'(b_in[i]);
            end
         end
         FUNC_MAG, FUNC_NORM: begin
            for (int i = 0; i < 3; i++) begin
               st0_x_in[2*i] = a_in[i];
               st0_y_in[2*i] = 33'(a_in[i]);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st0_v_ff <= 1'b0;
      end else begin
         st0_v_ff <= start;
      end
      st0_func_ff <= req_func;
      st0_neg_ff  <= st0_neg_in;
      for (int i = 0; i < 6; i++) begin
         st0_x_ff[i] <= st0_x_in[i];
         st0_y_ff[i] <= st0_y_in[i];
      end
      for (int i = 0; i < 3; i++) begin
         st0_a_ff[i] <= a_in[i];
         st0_b_ff[i] <= b_in[i];
      end
   end

   // ---------------- stage 1: products ----------------
   logic               st1_v_ff;
   logic [3:0]         st1_func_ff;
   logic signed [PW-1:0] st1_p_ff [6];
   logic [2:0]         st1_neg_ff;
   logic signed [31:0] st1_a_ff [3];
   logic signed [31:0] st1_b_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_v_ff <= 1'b0;
      end else begin
         st1_v_ff <= st0_v_ff;
      end
      st1_func_ff <= st0_func_ff;
      st1_neg_ff  <= st0_neg_ff;
      for (int i = 0; i < 6; i++) begin
         st1_p_ff[i] <= PW'(st0_x_ff[i]) * PW'(st0_y_ff[i]);
      end
      for (int i = 0; i < 3; i++) begin
         st1_a_ff[i] <= st0_a_ff[i];
         st1_b_ff[i] <= st0_b_ff[i];
      end
   end

   // ---------------- stage 2: exact sums ----------------
   logic signed [SW-1:0] st2_vsum_in [3];
   logic signed [33:0]   st2_lin_in [3];

   logic                 st2_v_ff;
   logic [3:0]           st2_func_ff;
   logic signed [SW-1:0] st2_vsum_ff [3];
   logic signed [SW-1:0] st2_tsum_ff;
   logic signed [33:0]   st2_lin_ff [3];
   logic signed [31:0]   st2_a_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (st1_neg_ff[i]) begin
            st2_vsum_in[i] = SW'(st1_p_ff[2*i]) - SW'(st1_p_ff[2*i+1]);
         end else begin
            st2_vsum_in[i] = SW'(st1_p_ff[2*i]) + SW'(st1_p_ff[2*i+1]);
         end
         case (st1_func_ff)
            FUNC_ADD: st2_lin_in[i] = 34'(st1_a_ff[i]) + 34'(st1_b_ff[i]);
            FUNC_SUB: st2_lin_in[i] = 34'(st1_a_ff[i]) - 34'(st1_b_ff[i]);
            FUNC_NEG: st2_lin_in[i] = 34'sd0 - 34'(st1_a_ff[i]);
            default:  st2_lin_in[i] = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st2_v_ff <= 1'b0;
      end else begin
         st2_v_ff <= st1_v_ff;
      end
      st2_func_ff <= st1_func_ff;
      st2_tsum_ff <= SW'(st1_p_ff[0]) + SW'(st1_p_ff[2]) + SW'(st1_p_ff[4]);
      for (int i = 0; i < 3; i++) begin
         st2_vsum_ff[i] <= st2_vsum_in[i];
         st2_lin_ff[i]  <= st2_lin_in[i];
         st2_a_ff[i]    <= st1_a_ff[i];
      end
   end

   // ---------------- stage 3: round, saturate, start the root ----------------
   side_type    side_in;
   logic [32:0] rs_v [3];
   logic [32:0] ls_v [3];
   logic [32:0] ds_v;

   logic        sq_v_ff    [SQ+1];
   logic [63:0] sq_s_ff    [SQ+1];
   logic [33:0] sq_r_ff    [SQ+1];
   logic [31:0] sq_q_ff    [SQ+1];
   side_type    sq_side_ff [SQ+1];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rs_v[i] = round_sat(st2_vsum_ff[i]);
         ls_v[i] = sat34(st2_lin_ff[i]);
      end
      ds_v = round_sat(st2_tsum_ff);
      side_in = '0;
      side_in.func = st2_func_ff;
      case (st2_func_ff)
         FUNC_ADD, FUNC_SUB, FUNC_NEG: begin
            side_in.rx  = ls_v[0][31:0];
            side_in.ry  = ls_v[1][31:0];
            side_in.rz  = ls_v[2][31:0];
            side_in.ovf = ls_v[0][32] | ls_v[1][32] | ls_v[2][32];
         end
         FUNC_SCALE, FUNC_CROSS, FUNC_LERP: begin
            side_in.rx  = rs_v[0][31:0];
            side_in.ry  = rs_v[1][31:0];
            side_in.rz  = rs_v[2][31:0];
            side_in.ovf = rs_v[0][32] | rs_v[1][32] | rs_v[2][32];
         end
         FUNC_DOT: begin
            side_in.sc  = ds_v[31:0];
            side_in.ovf = ds_v[32];
         end
         FUNC_NORM: begin
            for (int i = 0; i < 3; i++) begin
               side_in.sgn[i] = st2_a_ff[i][31];
               if (st2_a_ff[i][31]) begin
                  side_in.mag_abs[i] = ~st2_a_ff[i] + 32'd1;
               end else begin
                  side_in.mag_abs[i] = st2_a_ff[i];
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else begin
         sq_v_ff[0] <= st2_v_ff;
      end
      sq_s_ff[0]    <= st2_tsum_ff[63:0];
      sq_r_ff[0]    <= '0;
      sq_q_ff[0]    <= '0;
      sq_side_ff[0] <= side_in;
   end

   // ---------------- square root: one root bit per stage ----------------
   for (genvar k = 0; k < SQ; k++) begin : g_sqrt
      logic [35:0] part_in;
      logic [33:0] trial_in;
      logic        take_in;

      assign part_in  = {sq_r_ff[k], sq_s_ff[k][63:62]};
      assign trial_in = {sq_q_ff[k], 2'b01};
      assign take_in  = part_in >= {2'b00, trial_in};

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k+1] <= 1'b0;
         end else begin
            sq_v_ff[k+1] <= sq_v_ff[k];
         end
         sq_s_ff[k+1]    <= {sq_s_ff[k][61:0], 2'b00};
         sq_r_ff[k+1]    <= take_in ? 34'(part_in - {2'b00, trial_in}) : part_in[33:0];
         sq_q_ff[k+1]    <= {sq_q_ff[k][30:0], take_in};
         sq_side_ff[k+1] <= sq_side_ff[k];
      end
   end

   // ---------------- round the root, set up the divides ----------------
   logic [32:0]   mag_in;
   logic [NW-1:0] num_in [3];
   side_type      mside_in;

   logic          dv_v_ff    [QW+1];
   logic [32:0]   dv_m_ff    [QW+1];
   logic [32:0]   dv_r_ff    [QW+1][3];
   logic [QW-1:0] dv_n_ff    [QW+1][3];
   logic [QW-1:0] dv_q_ff    [QW+1][3];
   side_type      dv_side_ff [QW+1];

   always_comb begin
      mag_in = {1'b0, sq_q_ff[SQ]} + 33'(sq_r_ff[SQ] > {2'b00, sq_q_ff[SQ]});
      for (int i = 0; i < 3; i++) begin
         num_in[i] = {1'b0, sq_side_ff[SQ].mag_abs[i], FRAC_BITS'(0)} + NW'(mag_in >> 1);
      end
      mside_in = sq_side_ff[SQ];
      if (sq_side_ff[SQ].func == FUNC_MAG) begin
         mside_in.ovf = mag_in[32] | mag_in[31];
         mside_in.sc  = (mag_in[32] | mag_in[31]) ? 32'h7FFFFFFF : mag_in[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else begin
         dv_v_ff[0] <= sq_v_ff[SQ];
      end
      dv_m_ff[0]    <= mag_in;
      dv_side_ff[0] <= mside_in;
      for (int i = 0; i < 3; i++) begin
         dv_r_ff[0][i] <= 33'(num_in[i] >> QW);
         dv_n_ff[0][i] <= num_in[i][QW-1:0];
         dv_q_ff[0][i] <= '0;
      end
   end

   // ---------------- divide: one quotient bit per stage, three lanes ----------------
   for (genvar j = 0; j < QW; j++) begin : g_div
      logic [33:0] part_in [3];
      logic        take_in [3];

      for (genvar c = 0; c < 3; c++) begin : g_lane
         assign part_in[c] = {dv_r_ff[j][c], dv_n_ff[j][c][QW-1]};
         assign take_in[c] = part_in[c] >= {1'b0, dv_m_ff[j]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[j+1] <= 1'b0;
         end else begin
            dv_v_ff[j+1] <= dv_v_ff[j];
         end
         dv_m_ff[j+1]    <= dv_m_ff[j];
         dv_side_ff[j+1] <= dv_side_ff[j];
         for (int c = 0; c < 3; c++) begin
            dv_r_ff[j+1][c] <= take_in[c] ? 33'(part_in[c] - {1'b0, dv_m_ff[j]})
                                          : part_in[c][32:0];
            dv_n_ff[j+1][c] <= dv_n_ff[j][c] << 1;
            dv_q_ff[j+1][c] <= {dv_q_ff[j][c][QW-2:0], take_in[c]};
         end
      end
   end

   // ---------------- output register ----------------
   logic [31:0] res_in [3];
   logic        out_v_ff;
   logic [31:0] out_r_ff [3];
   logic [31:0] out_sc_ff;
   logic        out_ovf_ff;

   always_comb begin
      res_in[0] = dv_side_ff[QW].rx;
      res_in[1] = dv_side_ff[QW].ry;
      res_in[2] = dv_side_ff[QW].rz;
      if (dv_side_ff[QW].func == FUNC_NORM && dv_m_ff[QW] != '0) begin
         for (int i = 0; i < 3; i++) begin
            if (dv_side_ff[QW].sgn[i]) begin
               res_in[i] = 32'd0 - 32'(dv_q_ff[QW][i]);
            end else begin
               res_in[i] = 32'(dv_q_ff[QW][i]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= dv_v_ff[QW];
      end
      for (int i = 0; i < 3; i++) begin
         out_r_ff[i] <= res_in[i];
      end
      out_sc_ff  <= dv_side_ff[QW].sc;
      out_ovf_ff <= dv_side_ff[QW].ovf;
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_rx         = signed'(out_r_ff[0]);
   assign rsp_ry         = signed'(out_r_ff[1]);
   assign rsp_rz         = signed'(out_r_ff[2]);
   assign rsp_scalar_out = signed'(out_sc_ff);
   assign rsp_overflow   = out_ovf_ff;

endmodule

@@ rtl/v3a_checker.sv @@
module v3a_checker (
   input logic               clock,
   input logic               reset,
   input logic               busy,
   input logic               rsp_valid,
   input logic signed [31:0] rsp_rx,
   input logic signed [31:0] rsp_ry,
   input logic signed [31:0] rsp_rz,
   input logic signed [31:0] rsp_scalar_out,
   input logic               rsp_overflow
);

   // pipeline never refuses a transaction
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   // reset empties the pipeline
   a_reset_flush: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result strobe right after reset");

   // scalar and vector results never share a transaction
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_scalar_out != 0) |-> (rsp_rx == 0 && rsp_ry == 0 && rsp_rz == 0))
      else $error("scalar and vector result both nonzero");

   // a flagged scalar result sits at a rail
   a_scalar_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow && rsp_scalar_out != 0) |->
      (rsp_scalar_out == 32'sh7FFFFFFF || rsp_scalar_out == 32'sh80000000))
      else $error("overflow on scalar result off the rail");

endmodule

bind vec3_arith_unit v3a_checker u_v3a_checker (
   .clock          (clock),
   .reset          (reset),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_rx         (rsp_rx),
   .rsp_ry         (rsp_ry),
   .rsp_rz         (rsp_rz),
   .rsp_scalar_out (rsp_scalar_out),
   .rsp_overflow   (rsp_overflow)
);
